[design/mpre_pkg.sv]
// Shared types and constants for the MED predictive residual encoder.
package mpre_pkg;

    localparam int CHANNELS = 4;
    localparam int SAMPLE_W = 8;
    localparam int WIDTH_W  = 11;
    localparam int HEIGHT_W = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 1'b1;

    localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 11'd1024;
    localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 16'd1;

    typedef logic [SAMPLE_W-1:0] sample_t;
    typedef logic [CHANNELS-1:0][SAMPLE_W-1:0] pix_t;

endpackage

[design/mpre_pix_if.sv]
// Pixel input channel: four samples with valid/ready handshake.
interface mpre_pix_if;
    logic                          valid;
    logic                          ready;
    logic [mpre_pkg::SAMPLE_W-1:0] chan0;
    logic [mpre_pkg::SAMPLE_W-1:0] chan1;
    logic [mpre_pkg::SAMPLE_W-1:0] chan2;
    logic [mpre_pkg::SAMPLE_W-1:0] chan3;

    modport source (output valid, chan0, chan1, chan2, chan3, input ready);
    modport sink   (input valid, chan0, chan1, chan2, chan3, output ready);
endinterface

[design/mpre_res_if.sv]
// Residual output channel: four residual codes and end-of-image flag.
interface mpre_res_if;
    logic                          valid;
    logic                          ready;
    logic [mpre_pkg::SAMPLE_W-1:0] resid0;
    logic [mpre_pkg::SAMPLE_W-1:0] resid1;
    logic [mpre_pkg::SAMPLE_W-1:0] resid2;
    logic [mpre_pkg::SAMPLE_W-1:0] resid3;
    logic                          image_end;

    modport source (output valid, resid0, resid1, resid2, resid3, image_end, input ready);
    modport sink   (input valid, resid0, resid1, resid2, resid3, image_end, output ready);
endinterface

[design/med_predictive_residual_encoder_top.sv]
// Top level of the MED predictive residual encoder with line buffer.
// An accepted pixel passes the stage-1 registers, then the output register, to res.
// Throughput: one pixel per cycle while res.ready holds; the line memory does one read and one
// write per pixel, both at the edge that accepts it.
// Reset: counters, neighbor registers and pipeline valids clear; width = 1024,
// height = 1; the line memory is not cleared.
module med_predictive_residual_encoder_top #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                             clk,
    input  logic                             rst_n,
    mpre_pix_if.sink                         pix,
    mpre_res_if.source                       res,
    input  logic                             cfg_we,
    input  logic [mpre_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [mpre_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import mpre_pkg::*;

    localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int CMP_W = (COL_W + 1 > WIDTH_W) ? COL_W + 1 : WIDTH_W;
    localparam logic [CMP_W-1:0] MAX_W_C = CMP_W'(MAX_WIDTH);

    logic [WIDTH_W-1:0]  width_reg;
    logic [HEIGHT_W-1:0] height_reg;
    logic [COL_W-1:0]    col_reg;
    logic [HEIGHT_W-1:0] row_reg;
    pix_t                left_reg;
    pix_t                upleft_reg;

    logic                s1_valid_reg;
    pix_t                s1_cur_reg;
    pix_t                s1_left_reg;
    logic                s1_top_row_reg;
    logic                s1_last_col_reg;
    logic                s1_end_reg;
    pix_t                rd_reg;

    logic                out_valid_reg;
    pix_t                out_resid_reg;
    logic                out_end_reg;

    pix_t                line_mem [MAX_WIDTH];

    logic [CMP_W-1:0]    width_ext;
    logic [CMP_W-1:0]    eff_w;
    logic [CMP_W-1:0]    col_inc;
    logic [HEIGHT_W:0]   eff_h;
    logic [HEIGHT_W:0]   row_inc;
    logic                last_col;
    logic                last_row;
    logic [COL_W-1:0]    col_next;
    logic [HEIGHT_W-1:0] row_next;
    pix_t                cur;
    pix_t                up;
    pix_t                resid;
    logic                out_free;
    logic                s1_advance;
    logic                in_fire;

    assign width_ext = CMP_W'(width_reg);
    assign eff_w     = (width_ext == '0) ? CMP_W'(1)
                     : ((width_ext > MAX_W_C) ? MAX_W_C : width_ext);
    assign col_inc   = CMP_W'(col_reg) + CMP_W'(1);
    assign last_col  = col_inc >= eff_w;
    assign col_next  = last_col ? '0 : col_inc[COL_W-1:0];

    assign eff_h     = (height_reg == '0) ? (HEIGHT_W+1)'(1) : {1'b0, height_reg};
    assign row_inc   = {1'b0, row_reg} + (HEIGHT_W+1)'(1);
    assign last_row  = row_inc >= eff_h;
    assign row_next  = last_row ? '0 : row_inc[HEIGHT_W-1:0];

    assign cur = {pix.chan3, pix.chan2, pix.chan1, pix.chan0};

    assign out_free   = !out_valid_reg || res.ready;
    assign s1_advance = s1_valid_reg && out_free;
    assign pix.ready  = rst_n && (!s1_valid_reg || out_free);
    assign in_fire    = pix.valid && pix.ready;

    assign up = s1_top_row_reg ? '0 : rd_reg;

    for (genvar g = 0; g < CHANNELS; g++)
    begin : g_lane
        mpre_med u_med (
            .a    (s1_left_reg[g]),
            .b    (up[g]),
            .c    (upleft_reg[g]),
            .v    (s1_cur_reg[g]),
            .code (resid[g])
        );
    end

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_IMAGE_WIDTH:  width_reg  <= cfg_data[WIDTH_W-1:0];
                CFG_IMAGE_HEIGHT: height_reg <= cfg_data[HEIGHT_W-1:0];
                default:          ;
            endcase
        end
    end

    // raster counters and left neighbor, advance on accept
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            row_reg  <= '0;
            left_reg <= '0;
        end
        else if (in_fire)
        begin
            col_reg  <= col_next;
            left_reg <= last_col ? '0 : cur;
            if (last_col)
            begin
                row_reg <= row_next;
            end
        end
    end

    // line memory: read old entry and write the new pixel at the same column
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            line_mem[col_reg] <= cur;
            rd_reg            <= line_mem[col_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            upleft_reg   <= '0;
        end
        else
        begin
            if (in_fire)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_advance)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_advance)
            begin
                upleft_reg <= s1_last_col_reg ? '0 : up;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_cur_reg      <= cur;
            s1_left_reg     <= left_reg;
            s1_top_row_reg  <= (row_reg == '0);
            s1_last_col_reg <= last_col;
            s1_end_reg      <= last_col && last_row;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance)
        begin
            out_resid_reg <= resid;
            out_end_reg   <= s1_end_reg;
        end
    end

    assign res.valid     = out_valid_reg;
    assign res.resid0    = out_resid_reg[0];
    assign res.resid1    = out_resid_reg[1];
    assign res.resid2    = out_resid_reg[2];
    assign res.resid3    = out_resid_reg[3];
    assign res.image_end = out_end_reg;

    a_image_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && last_col && last_row |=> col_reg == '0 && row_reg == '0)
        else $error("counters did not wrap at end of image");

    a_row_start: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && last_col |=> left_reg == '0)
        else $error("left neighbor not cleared at row start");

    a_stage_fill: assert property (@(posedge clk) disable iff (!rst_n)
        s1_advance |=> out_valid_reg)
        else $error("advanced word lost before output register");

endmodule

[design/mpre_med.sv]
// One channel of the median edge predictor and the lossy residual coder.
module mpre_med (
    input  mpre_pkg::sample_t a,
    input  mpre_pkg::sample_t b,
    input  mpre_pkg::sample_t c,
    input  mpre_pkg::sample_t v,
    output mpre_pkg::sample_t code
);
    import mpre_pkg::*;

    sample_t             mx;
    sample_t             mn;
    logic [SAMPLE_W:0]   sum;
    sample_t             pred;
    logic [SAMPLE_W:0]   diff;
    logic                neg;
    sample_t             mag;

    assign mx  = (a > b) ? a : b;
    assign mn  = (a > b) ? b : a;
    assign sum = {1'b0, a} + {1'b0, b} - {1'b0, c};

    always_comb
    begin
        if (c > mx)
        begin
            pred = mn;
        end
        else if (c < mn)
        begin
            pred = mx;
        end
        else
        begin
            pred = sum[SAMPLE_W-1:0];
        end
    end

    assign diff = {1'b0, v} - {1'b0, pred};
    assign neg  = diff[SAMPLE_W];
    assign mag  = neg ? SAMPLE_W'(-diff) : diff[SAMPLE_W-1:0];
    assign code = {mag[SAMPLE_W-1:1], neg};

endmodule
